// ----- sv/lzwe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW encoder package
// Code-space constants, the dictionary entry layout and the hash function.
// ----------------------------------------------------------------------------
package lzwe_pkg;

	localparam int CODE_BITS       = 12;
	localparam int FIRST_FREE_CODE = 256;
	localparam int CODE_SPACE      = 1 << CODE_BITS;
	localparam int NEXT_BITS       = CODE_BITS + 1;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [NEXT_BITS-1:0] next_code_t;

	// One hash-table slot: the (prefix, byte) key and the code it was given.
	typedef struct packed {
		logic       valid;
		code_t      prefix;
		logic [7:0] data;
		code_t      code;
	} dict_entry_t;

	localparam int ENTRY_BITS = $bits(dict_entry_t);

	// Spreads the byte over the top and bottom of the code word.
	function automatic code_t dict_hash(input code_t prefix, input logic [7:0] data);
		code_t hi;
		code_t lo;
		hi = {data, {(CODE_BITS - 8){1'b0}}};
		lo = CODE_BITS'(data);
		return prefix ^ hi ^ lo;
	endfunction

endpackage

// ----- sv/lzw_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW encoder
// Byte-in, code-out LZW compressor with a hashed dictionary in one RAM.
// ----------------------------------------------------------------------------
// The block takes one byte per input transaction and returns zero, one or two
// code words per byte. The dictionary is an open-addressed hash table of
// 2^CODE_BITS slots held in a single synchronous RAM; a lookup hashes the
// current prefix with the byte and probes consecutive slots until it finds the
// key or an empty slot. A byte that extends a known string is accepted with
// the first read issued, then compared; each extra probe reads the next slot,
// and each emitted code passes through an emit state in which the output
// register is loaded, held there while that register still holds a code not
// yet taken. The first byte of a string needs no lookup. After reset the block
// clears all 2^CODE_BITS slots (4096 with 12-bit codes), one slot per cycle,
// and accepts no transaction until that is done. Because at most
// 2^CODE_BITS - 256 entries are ever stored, at least 256 slots stay empty
// and every probe sequence ends.
// ----------------------------------------------------------------------------
module lzw_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   data_byte,
	input  logic                         end_of_string,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lzwe_pkg::CODE_BITS-1:0] code,
	output logic                         last_code
);

	import lzwe_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_EMIT_MISS,
		ST_EMIT_LAST
	} state_t;

	state_t      state_q;
	code_t       clr_cnt_q;
	code_t       addr_q;
	code_t       prefix_q;
	logic        prefix_valid_q;
	next_code_t  next_code_q;
	logic [7:0]  byte_q;
	logic        eos_q;
	code_t       miss_code_q;
	logic        out_valid_q;
	code_t       code_q;
	logic        last_q;

	logic        accept;
	logic        slot_free;
	logic        out_load;
	logic        ram_rd_en;
	code_t       ram_rd_addr;
	logic        ram_wr_en;
	code_t       ram_wr_addr;
	dict_entry_t ram_wr_data;
	logic [ENTRY_BITS-1:0] ram_rd_raw;
	dict_entry_t rd_entry;
	logic        hit;
	logic        space_left;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign slot_free  = !out_valid_q || out_ready;
	// The output register is loaded in either emit state once it is free.
	assign out_load   = ((state_q == ST_EMIT_MISS) || (state_q == ST_EMIT_LAST)) && slot_free;
	assign out_valid  = out_valid_q;
	assign code       = code_q;
	assign last_code  = last_q;
	assign rd_entry   = dict_entry_t'(ram_rd_raw);
	assign hit        = rd_entry.valid && (rd_entry.prefix == prefix_q) && (rd_entry.data == byte_q);
	assign space_left = (next_code_q < NEXT_BITS'(CODE_SPACE));

	// The first probe is issued at accept time; later probes walk to the next slot.
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = addr_q + CODE_BITS'(1);
		if (state_q == ST_IDLE) begin
			ram_rd_en   = accept && prefix_valid_q;
			ram_rd_addr = dict_hash(prefix_q, data_byte);
		end else if (state_q == ST_PROBE) begin
			ram_rd_en = rd_entry.valid && !hit;
		end
	end

	// Clearing pass after reset, or insertion into the empty slot found by a probe.
	always_comb begin
		ram_wr_en          = 1'b0;
		ram_wr_addr        = addr_q;
		ram_wr_data        = '0;
		if (state_q == ST_CLEAR) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_cnt_q;
		end else if (state_q == ST_PROBE && !rd_entry.valid && space_left) begin
			ram_wr_en          = 1'b1;
			ram_wr_data.valid  = 1'b1;
			ram_wr_data.prefix = prefix_q;
			ram_wr_data.data   = byte_q;
			ram_wr_data.code   = CODE_BITS'(next_code_q);
		end
	end

	lzwe_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(CODE_SPACE)
	) u_dict (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_cnt_q      <= '0;
			addr_q         <= '0;
			prefix_valid_q <= 1'b0;
			prefix_q       <= '0;
			next_code_q    <= NEXT_BITS'(FIRST_FREE_CODE);
			byte_q         <= '0;
			eos_q          <= 1'b0;
			miss_code_q    <= '0;
			out_valid_q    <= 1'b0;
			code_q         <= '0;
			last_q         <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + CODE_BITS'(1);
					if (clr_cnt_q == CODE_BITS'(CODE_SPACE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						byte_q <= data_byte;
						eos_q  <= end_of_string;
						addr_q <= ram_rd_addr;
						if (!prefix_valid_q) begin
							// First byte of a string: it simply becomes the prefix.
							prefix_q       <= CODE_BITS'(data_byte);
							prefix_valid_q <= 1'b1;
							if (end_of_string) begin
								state_q <= ST_EMIT_LAST;
							end
						end else begin
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (hit) begin
						prefix_q <= rd_entry.code;
						state_q  <= eos_q ? ST_EMIT_LAST : ST_IDLE;
					end else if (!rd_entry.valid) begin
						miss_code_q <= prefix_q;
						prefix_q    <= CODE_BITS'(byte_q);
						if (space_left) begin
							next_code_q <= next_code_q + NEXT_BITS'(1);
						end
						state_q <= ST_EMIT_MISS;
					end else begin
						addr_q <= ram_rd_addr;
					end
				end
				ST_EMIT_MISS: begin
					if (slot_free) begin
						code_q  <= miss_code_q;
						last_q  <= 1'b0;
						state_q <= eos_q ? ST_EMIT_LAST : ST_IDLE;
					end
				end
				ST_EMIT_LAST: begin
					if (slot_free) begin
						code_q         <= prefix_q;
						last_q         <= 1'b1;
						prefix_q       <= '0;
						prefix_valid_q <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An insertion must only ever land in a slot that was read as empty.
	a_insert_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE && ram_wr_en) |-> !rd_entry.valid)
		else $error("dictionary insert over an occupied slot");

	// The code counter never passes the end of the code space.
	a_next_code_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_code_q <= NEXT_BITS'(CODE_SPACE))
		else $error("next code beyond code space");

	// Flushing the last code always empties the prefix.
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LAST && slot_free) |=> (!prefix_valid_q && out_valid_q && last_q))
		else $error("last code flush did not empty the prefix");

	// No transaction is taken while the clearing pass runs.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("input accepted during dictionary clear");

endmodule

// ----- sv/lzwe_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lzwe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- tb/tb_lzw_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW encoder testbench
// Sends byte strings into the encoder and compares every code word it returns
// with an in-bench LZW model that keeps its own dictionary and prefix.
// ----------------------------------------------------------------------------
// The model mirrors the encoder: codes 0 to 255 are single bytes, new entries
// are numbered from 256, a miss emits the prefix code and a flagged last byte
// flushes the prefix with last_code set. Expected code words wait in a queue,
// and a checker process compares each output transaction with the oldest one.
// The run covers single-byte strings, long repetitive strings that grow deep
// entries, a long output stall and random strings.
// ----------------------------------------------------------------------------
module tb_lzw_encoder;
	import lzwe_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        end_of_string = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	code_t       code;
	logic        last_code;

	lzw_encoder uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_string(end_of_string),
		.out_valid(out_valid), .out_ready(out_ready),
		.code(code), .last_code(last_code)
	);

	always #2 clk = ~clk;

	// Model state: dictionary pairs by code, next free code and current prefix.
	code_t       dict_prefix [CODE_SPACE];
	logic [7:0]  dict_byte [CODE_SPACE];
	int          next_free;
	code_t       cur_prefix;
	logic        have_prefix;

	// Expected code words, packed as {last_code, code}.
	logic [CODE_BITS:0] pending_codes[$];
	int  mismatches = 0;
	bit  hold_output = 1'b0;
	bit  burst_mode = 1'b1;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Appends one expected code word to the queue.
	task automatic expect_code(input logic [CODE_BITS:0] word);
		pending_codes.insert(pending_codes.size(), word);
	endtask

	// Advances the model by one byte and queues the code words it produces.
	task automatic encode_byte(input logic [7:0] b, input logic eos);
		int found;
		found = -1;
		if (!have_prefix) begin
			cur_prefix = code_t'(b);
			have_prefix = 1'b1;
		end else begin
			for (int c = FIRST_FREE_CODE; c < next_free; c++)
				if (dict_prefix[c] == cur_prefix && dict_byte[c] == b) begin
					found = c;
					break;
				end
			if (found >= 0) begin
				cur_prefix = code_t'(found);
			end else begin
				expect_code({1'b0, cur_prefix});
				if (next_free < CODE_SPACE) begin
					dict_prefix[next_free] = cur_prefix;
					dict_byte[next_free] = b;
					next_free++;
				end
				cur_prefix = code_t'(b);
			end
		end
		if (eos) begin
			expect_code({1'b1, cur_prefix});
			cur_prefix = '0;
			have_prefix = 1'b0;
		end
	endtask

	// Offers one byte, holding it until the encoder accepts the transaction.
	// Valid stays high afterwards so that the next byte can follow at once.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		if (burst_mode && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_string <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		encode_byte(b, eos);
	endtask

	task automatic send_string(input int len, input int alphabet);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, alphabet - 1)), i == len - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_codes.size() != 0) @(posedge clk);
	endtask

	// Receiver: stalls on a pattern that changes over time, unless held off.
	always @(posedge clk) begin
		if (hold_output)
			out_ready <= 1'b0;
		else
			case ($urandom_range(0, 3))
				0: out_ready <= 1'b0;
				1: out_ready <= ($urandom_range(0, 7) != 0);
				default: out_ready <= 1'b1;
			endcase
	end

	// Checker: each accepted code word against the oldest expectation.
	always @(posedge clk) begin
		logic [CODE_BITS:0] want;
		if (out_valid && out_ready) begin
			if (pending_codes.size() == 0) begin
				report($sformatf("unexpected code %0d", code));
			end else begin
				want = pending_codes.pop_front();
				if (code !== want[CODE_BITS-1:0])
					report($sformatf("code %0d, wanted %0d", code, want[CODE_BITS-1:0]));
				if (last_code !== want[CODE_BITS])
					report($sformatf("last_code %b, wanted %b", last_code, want[CODE_BITS]));
			end
		end
	end

	// Single-byte strings at both byte extremes and every data bit set.
	task automatic test_single_bytes();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b1);
	endtask

	// Repetition builds chains of entries, so later bytes extend deep prefixes.
	task automatic test_repeats();
		for (int i = 0; i < 12; i++) send_byte(8'h41, i == 11);
		for (int i = 0; i < 9; i++) send_byte(i[0] ? 8'hFF : 8'h00, i == 8);
	endtask

	// Output held off for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		hold_output = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_output = 1'b0;
			end
			send_string(40, 4);
		join
		wait_drained();
	endtask

	// Random strings over small and full alphabets, mostly in bursts.
	task automatic test_random_strings();
		int sent;
		sent = 0;
		while (sent < 330) begin
			int len;
			len = $urandom_range(1, 24);
			burst_mode = ($urandom_range(0, 3) != 0);
			send_string(len, $urandom_range(0, 1) ? 256 : $urandom_range(2, 8));
			sent += len;
			if ($urandom_range(0, 15) == 0) wait_drained();
		end
		burst_mode = 1'b1;
	endtask

	initial begin
		next_free = FIRST_FREE_CODE;
		cur_prefix = '0;
		have_prefix = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_single_bytes();
		test_repeats();
		test_backpressure();
		test_random_strings();
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_codes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// The clearing pass and a few hundred bytes need well under a tenth of this.
	initial begin
		#1ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- lzw_encoder.f -----
sv/lzwe_pkg.sv
sv/lzwe_ram.sv
sv/lzw_encoder.sv
tb/tb_lzw_encoder.sv
